FILE: src/lscd_pkg.sv
// Package with the shared types and constants of the sector cache directory.
package lscd_pkg;

  localparam int unsigned DefEntries    = 64;
  localparam int unsigned DefSectorBits = 32;
  localparam int unsigned CmdW          = 3;
  localparam int unsigned DevW          = 4;
  localparam int unsigned SecW          = 32;
  localparam int unsigned SlotW         = 6;
  localparam int unsigned CountW        = 32;
  localparam int unsigned QueueDepth    = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_READ  = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_FLUSH = 3'd2,
    CMD_INVAL = 3'd3,
    CMD_TAKE  = 3'd4,
    CMD_OTHER = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    KIND_ACCESS = 2'd0,
    KIND_WB     = 2'd1,
    KIND_DONE   = 2'd2
  } kind_e;

  // States of the back end's sequencer.
  typedef enum logic [2:0] {
    ST_IDLE, ST_LOOKUP, ST_SCAN, ST_VWB, ST_ACC, ST_FLUSH, ST_FEND, ST_CMD
  } state_e;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [DevW-1:0] dev_id;
    logic [SecW-1:0] sector_num;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SlotW-1:0]  slot;
    logic              hit;
    logic              fill_needed;
    logic [DevW-1:0]   out_dev;
    logic [SecW-1:0]   out_sector;
    logic [CountW-1:0] access_count;
    logic [CountW-1:0] hit_count;
    logic              last;
  } out_item_t;

  // One decoded command as it waits between the front and the back.
  typedef struct packed {
    op_e             op;
    logic [DevW-1:0] dev;
    logic [SecW-1:0] sector;
  } q_item_t;

  // Handshake between the queue and the back end.
  typedef struct packed {
    logic empty;
    logic pop;
  } q_ctrl_t;

endpackage

FILE: src/lscd_front.sv
// Front end: accepts commands, decodes them and masks the sector number.
module lscd_front import lscd_pkg::*; #(
  parameter int unsigned SECTOR_BITS = DefSectorBits
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output q_item_t  q_item_o
);

  logic    hold_v_q, hold_v_d;
  q_item_t hold_q;
  q_item_t dec;
  logic    take;
  logic [SecW+SECTOR_BITS-1:0] sec_ext;

  always_comb begin
    sec_ext = {{SecW{1'b0}}, in_item_i.sector_num[SECTOR_BITS-1:0]};
    dec.dev    = in_item_i.dev_id;
    dec.sector = sec_ext[SecW-1:0];
    unique case (in_item_i.cmd)
      CMD_READ:  dec.op = CMD_READ;
      CMD_WRITE: dec.op = CMD_WRITE;
      CMD_FLUSH: dec.op = CMD_FLUSH;
      CMD_INVAL: dec.op = CMD_INVAL;
      CMD_TAKE:  dec.op = CMD_TAKE;
      default:   dec.op = CMD_OTHER;
    endcase
  end

  assign in_stall_o = hold_v_q && q_full_i;
  assign take       = in_valid_i && !in_stall_o;
  assign q_push_o   = hold_v_q && !q_full_i;
  assign q_item_o   = hold_q;

  always_comb begin
    hold_v_d = hold_v_q;
    if (take) begin
      hold_v_d = 1'b1;
    end else if (q_push_o) begin
      hold_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
    end else begin
      hold_v_q <= hold_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      hold_q <= dec;
    end
  end

endmodule

FILE: src/lscd_queue.sv
// Short command queue between the front end and the back end.
module lscd_queue import lscd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_item_t item_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    empty_o,
  output q_item_t head_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  q_item_t         mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(QueueDepth);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QueueDepth)) else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_push_nonfull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");

endmodule

FILE: src/lscd_back.sv
// Back end: tag lookup, recency sweep, flush sequencing and result register.
module lscd_back import lscd_pkg::*; #(
  parameter int unsigned ENTRIES     = DefEntries,
  parameter int unsigned SECTOR_BITS = DefSectorBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_ctrl_t   q_ctrl_i,
  output logic      q_pop_o,
  input  q_item_t   q_head_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned SW = SECTOR_BITS;

  state_e state_q, state_d;

  logic            valid_q [ENTRIES];
  logic            dirty_q [ENTRIES];
  logic [IW-1:0]   rank_q  [ENTRIES];
  logic [DevW-1:0] tdev_q  [ENTRIES];
  logic [SW-1:0]   tsec_q  [ENTRIES];

  op_e               op_q;
  logic [DevW-1:0]   dev_q;
  logic [SW-1:0]     sec_q;
  logic [IW-1:0]     sweep_q, slot_q, rk_q, pslot_q;
  logic              hit_q, pend_q;
  logic [DevW-1:0]   pdev_q;
  logic [SW-1:0]     psec_q;
  logic [CountW-1:0] acc_q, hitc_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic [ENTRIES-1:0] hit_vec, hot;
  logic [IW-1:0]      hit_idx, hit_rank, sel_idx;
  logic               hit_any, sel_valid, sel_dirty;
  logic [DevW-1:0]    sel_dev;
  logic [SW-1:0]      sel_sec;

  logic      can_emit, emit, is_wr, last_sweep, found;
  out_item_t res;
  logic do_load, do_lookup, do_pick, do_step, do_take, do_commit, do_fend, do_cmd;

  function automatic logic [SlotW-1:0] to_slot(input logic [IW-1:0] idx);
    logic [SlotW+IW-1:0] ext;
    ext = {{SlotW{1'b0}}, idx};
    return ext[SlotW-1:0];
  endfunction

  function automatic logic [SecW-1:0] to_sec(input logic [SW-1:0] s);
    logic [SecW+SW-1:0] ext;
    ext = {{SecW{1'b0}}, s};
    return ext[SecW-1:0];
  endfunction

  // Parallel tag compare and rank match; tags are unique and ranks a
  // permutation, so the matches are OR-encoded.
  always_comb begin
    hit_idx   = '0;
    hit_rank  = '0;
    sel_idx   = '0;
    sel_valid = 1'b0;
    sel_dirty = 1'b0;
    sel_dev   = '0;
    sel_sec   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid_q[i] && (tdev_q[i] == dev_q) && (tsec_q[i] == sec_q);
      hot[i]     = rank_q[i] == sweep_q;
      if (hit_vec[i]) begin
        hit_idx  = hit_idx | IW'(i);
        hit_rank = hit_rank | rank_q[i];
      end
      if (hot[i]) begin
        sel_idx   = sel_idx | IW'(i);
        sel_valid = sel_valid | valid_q[i];
        sel_dirty = sel_dirty | dirty_q[i];
        sel_dev   = sel_dev | tdev_q[i];
        sel_sec   = sel_sec | tsec_q[i];
      end
    end
    hit_any = |hit_vec;
  end

  assign can_emit   = !out_valid_q || !out_stall_i;
  assign is_wr      = op_q == CMD_WRITE;
  assign last_sweep = sweep_q == IW'(ENTRIES - 1);
  assign found      = sel_valid && sel_dirty;

  always_comb begin
    state_d   = state_q;
    emit      = 1'b0;
    res       = '0;
    q_pop_o   = 1'b0;
    do_load   = 1'b0;
    do_lookup = 1'b0;
    do_pick   = 1'b0;
    do_step   = 1'b0;
    do_take   = 1'b0;
    do_commit = 1'b0;
    do_fend   = 1'b0;
    do_cmd    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_ctrl_i.empty) begin
          q_pop_o = 1'b1;
          do_load = 1'b1;
          unique case (q_head_i.op)
            CMD_READ, CMD_WRITE: state_d = ST_LOOKUP;
            CMD_FLUSH, CMD_INVAL: state_d = ST_FLUSH;
            default: state_d = ST_CMD;
          endcase
        end
      end
      ST_LOOKUP: begin
        do_lookup = 1'b1;
        state_d   = hit_any ? ST_ACC : ST_SCAN;
      end
      ST_SCAN: begin
        if (!sel_valid || last_sweep) begin
          do_pick = 1'b1;
          state_d = found ? ST_VWB : ST_ACC;
        end else begin
          do_step = 1'b1;
        end
      end
      ST_VWB: begin
        if (can_emit) begin
          emit       = 1'b1;
          res.kind   = KIND_WB;
          res.slot   = to_slot(slot_q);
          res.out_dev    = pdev_q;
          res.out_sector = to_sec(psec_q);
          res.access_count = acc_q;
          res.hit_count    = hitc_q;
          state_d    = ST_ACC;
        end
      end
      ST_ACC: begin
        if (can_emit) begin
          emit        = 1'b1;
          do_commit   = 1'b1;
          res.kind    = KIND_ACCESS;
          res.slot    = to_slot(slot_q);
          res.hit     = hit_q;
          res.fill_needed = !hit_q && !is_wr;
          res.out_dev     = dev_q;
          res.out_sector  = to_sec(sec_q);
          res.access_count = acc_q;
          res.hit_count    = hitc_q;
          res.last    = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (!(found && pend_q && !can_emit)) begin
          if (found && pend_q) begin
            emit       = 1'b1;
            res.kind   = KIND_WB;
            res.slot   = to_slot(pslot_q);
            res.out_dev    = pdev_q;
            res.out_sector = to_sec(psec_q);
            res.access_count = acc_q;
            res.hit_count    = hitc_q;
          end
          do_take = found;
          if (last_sweep) begin
            state_d = ST_FEND;
          end else begin
            do_step = 1'b1;
          end
        end
      end
      ST_FEND: begin
        if (can_emit) begin
          emit    = 1'b1;
          do_fend = 1'b1;
          res.last = 1'b1;
          if (pend_q) begin
            res.kind   = KIND_WB;
            res.slot   = to_slot(pslot_q);
            res.out_dev    = pdev_q;
            res.out_sector = to_sec(psec_q);
            res.access_count = acc_q;
            res.hit_count    = hitc_q;
          end else begin
            res.kind = KIND_DONE;
            if (op_q != CMD_INVAL) begin
              res.access_count = acc_q;
              res.hit_count    = hitc_q;
            end
          end
          state_d = ST_IDLE;
        end
      end
      ST_CMD: begin
        if (can_emit) begin
          emit     = 1'b1;
          do_cmd   = 1'b1;
          res.kind = KIND_DONE;
          res.access_count = acc_q;
          res.hit_count    = hitc_q;
          res.last = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control state: marks, ranks, counters, sweep and pending flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
        dirty_q[i] <= 1'b0;
        rank_q[i]  <= IW'(ENTRIES - 1 - i);
      end
      acc_q       <= '0;
      hitc_q      <= '0;
      sweep_q     <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (do_load) begin
        sweep_q <= '0;
        pend_q  <= 1'b0;
        hit_q   <= 1'b0;
      end
      if (do_step) begin
        sweep_q <= sweep_q + 1'b1;
      end
      if (do_lookup) begin
        if (acc_q != '1) begin
          acc_q <= acc_q + 1'b1;
        end
        if (hit_any) begin
          hit_q <= 1'b1;
          if (hitc_q != '1) begin
            hitc_q <= hitc_q + 1'b1;
          end
        end
      end
      if (do_take) begin
        pend_q           <= 1'b1;
        dirty_q[sel_idx] <= 1'b0;
      end
      if (do_commit) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (rank_q[i] < rk_q) begin
            rank_q[i] <= rank_q[i] + 1'b1;
          end
        end
        rank_q[slot_q] <= '0;
        if (!hit_q) begin
          valid_q[slot_q] <= 1'b1;
          dirty_q[slot_q] <= is_wr;
        end else if (is_wr) begin
          dirty_q[slot_q] <= 1'b1;
        end
      end
      if (do_fend) begin
        pend_q <= 1'b0;
        if (op_q == CMD_INVAL) begin
          for (int i = 0; i < ENTRIES; i++) begin
            valid_q[i] <= 1'b0;
          end
          acc_q  <= '0;
          hitc_q <= '0;
        end
      end
      if (do_cmd && op_q == CMD_TAKE) begin
        acc_q  <= '0;
        hitc_q <= '0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers and tag store.
  always_ff @(posedge clk_i) begin
    if (do_load) begin
      op_q  <= q_head_i.op;
      dev_q <= q_head_i.dev;
      sec_q <= q_head_i.sector[SW-1:0];
    end
    if (do_lookup) begin
      slot_q <= hit_idx;
      rk_q   <= hit_rank;
    end
    if (do_pick) begin
      slot_q <= sel_idx;
      rk_q   <= sweep_q;
      pdev_q <= sel_dev;
      psec_q <= sel_sec;
    end
    if (do_take) begin
      pslot_q <= sel_idx;
      pdev_q  <= sel_dev;
      psec_q  <= sel_sec;
    end
    if (do_commit && !hit_q) begin
      tdev_q[slot_q] <= dev_q;
      tsec_q[slot_q] <= sec_q;
    end
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !pend_q) else $error("pending write-back left over");
  a_tag_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOOKUP |-> $onehot0(hit_vec)) else $error("duplicate tag");
  a_rank_perm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_FLUSH) |-> $onehot(hot))
    else $error("recency ranks are not a permutation");
  a_hits_le_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hitc_q <= acc_q) else $error("hit count exceeds access count");

endmodule

FILE: src/lru_sector_cache_directory_top.sv
// Top level of the fully associative LRU write-back sector cache directory.
// Commands enter a front end that decodes them into a two-item queue, and a
// back end executes them one at a time and delivers result items through an
// output register. A read or write hit passes from the queue head to its
// result through a load step, the parallel tag compare across all entries,
// a step that builds the result, and the output register that presents it.
// A miss adds a recency sweep that walks ranks from most recent upward, one
// rank per cycle, and stops at the first invalid entry or at the least
// recent one; a dirty victim then gives a write-back item. Flush and
// invalidate always sweep all ENTRIES ranks, giving one write-back item per
// dirty entry in recency order. Stalls on the result side hold all of these
// back. The slot field of each result addresses an external sector data
// store.
module lru_sector_cache_directory_top import lscd_pkg::*; #(
  parameter int unsigned ENTRIES     = DefEntries,
  parameter int unsigned SECTOR_BITS = DefSectorBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic    q_full, q_push, q_pop;
  q_item_t q_in, q_head;
  q_ctrl_t q_ctrl;

  lscd_front #(.SECTOR_BITS(SECTOR_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_in)
  );

  lscd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_ctrl.empty),
    .head_o  (q_head)
  );

  assign q_ctrl.pop = q_pop;

  lscd_back #(.ENTRIES(ENTRIES), .SECTOR_BITS(SECTOR_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_ctrl_i    (q_ctrl),
    .q_pop_o     (q_pop),
    .q_head_i    (q_head),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: test/lscd_checker.sv
// Checker that predicts the cache directory's result items and compares them.
`timescale 1ns / 1ps
module lscd_checker import lscd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        pending_o
);

  localparam int unsigned N = DefEntries;

  logic             valid_m [N];
  logic             dirty_m [N];
  logic [DevW-1:0]  tag_dev [N];
  logic [SecW-1:0]  tag_sec [N];
  int unsigned      rank_m  [N];
  logic [CountW-1:0] acc_tot, hit_tot;

  out_item_t expected_q[$];
  int        fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

  function automatic out_item_t mk(kind_e k, int unsigned s, logic h, logic f,
                                   logic [DevW-1:0] d, logic [SecW-1:0] sc,
                                   logic l);
    out_item_t r;
    r.kind = k; r.slot = s[SlotW-1:0]; r.hit = h; r.fill_needed = f;
    r.out_dev = d; r.out_sector = sc; r.access_count = acc_tot;
    r.hit_count = hit_tot; r.last = l;
    return r;
  endfunction

  task automatic make_recent(int unsigned s);
    int unsigned r;
    r = rank_m[s];
    for (int i = 0; i < N; i++) if (rank_m[i] < r) rank_m[i]++;
    rank_m[s] = 0;
  endtask

  // Write back every dirty entry, most recent first; returns the count.
  task automatic flush_all(output int n);
    int unsigned order [N];
    n = 0;
    for (int i = 0; i < N; i++) order[rank_m[i]] = i;
    for (int r = 0; r < N; r++) begin
      if (valid_m[order[r]] && dirty_m[order[r]]) begin
        expected_q.push_back(mk(KIND_WB, order[r], 0, 0, tag_dev[order[r]],
                                tag_sec[order[r]], 0));
        dirty_m[order[r]] = 0;
        n++;
      end
    end
    if (n > 0) expected_q[$].last = 1'b1;
  endtask

  task automatic do_access(logic wr, logic [DevW-1:0] d, logic [SecW-1:0] sc);
    int unsigned s, best;
    logic found;
    found = 0; s = N; best = N + 1;
    if (acc_tot != '1) acc_tot++;
    for (int i = 0; i < N; i++)
      if (!found && valid_m[i] && tag_dev[i] == d && tag_sec[i] == sc) begin
        s = i; found = 1;
      end
    if (found) begin
      if (hit_tot != '1) hit_tot++;
    end else begin
      for (int i = 0; i < N; i++)
        if (!valid_m[i] && rank_m[i] < best) begin
          best = rank_m[i]; s = i;
        end
      if (s >= N) begin
        s = 0;
        for (int i = 0; i < N; i++) if (rank_m[i] == N - 1) s = i;
      end
      if (valid_m[s] && dirty_m[s])
        expected_q.push_back(mk(KIND_WB, s, 0, 0, tag_dev[s], tag_sec[s], 0));
      valid_m[s] = 1; dirty_m[s] = 0; tag_dev[s] = d; tag_sec[s] = sc;
    end
    if (wr) dirty_m[s] = 1;
    make_recent(s);
    expected_q.push_back(mk(KIND_ACCESS, s, found, !found && !wr, d, sc, 1));
  endtask

  task automatic predict(in_item_t it);
    int n;
    case (op_e'(it.cmd))
      CMD_READ:  do_access(0, it.dev_id, it.sector_num);
      CMD_WRITE: do_access(1, it.dev_id, it.sector_num);
      CMD_FLUSH: begin
        flush_all(n);
        if (n == 0) expected_q.push_back(mk(KIND_DONE, 0, 0, 0, 0, 0, 1));
      end
      CMD_INVAL: begin
        flush_all(n);
        for (int i = 0; i < N; i++) valid_m[i] = 0;
        acc_tot = 0; hit_tot = 0;
        if (n == 0) expected_q.push_back(mk(KIND_DONE, 0, 0, 0, 0, 0, 1));
      end
      CMD_TAKE: begin
        expected_q.push_back(mk(KIND_DONE, 0, 0, 0, 0, 0, 1));
        acc_tot = 0; hit_tot = 0;
      end
      default: expected_q.push_back(mk(KIND_DONE, 0, 0, 0, 0, 0, 1));
    endcase
  endtask

  task automatic cmp(string nm, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $error("%s mismatch: expected %0h, got %0h", nm, e, a);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e, a;
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        valid_m[i] = 0; dirty_m[i] = 0; tag_dev[i] = 0; tag_sec[i] = 0;
        rank_m[i] = N - 1 - i;
      end
      acc_tot = 0; hit_tot = 0;
      expected_q.delete();
      fails = 0;
    end else begin
      if (in_valid_i && !in_stall_i) predict(in_item_i);
      if (out_valid_i && !out_stall_i) begin
        a = out_item_i;
        if (expected_q.size() == 0) begin
          $error("unexpected result item: %p", a);
          fails++;
        end else begin
          e = expected_q.pop_front();
          cmp("kind", e.kind, a.kind);
          cmp("slot", e.slot, a.slot);
          cmp("hit", e.hit, a.hit);
          cmp("fill_needed", e.fill_needed, a.fill_needed);
          cmp("out_dev", e.out_dev, a.out_dev);
          cmp("out_sector", e.out_sector, a.out_sector);
          cmp("access_count", e.access_count, a.access_count);
          cmp("hit_count", e.hit_count, a.hit_count);
          cmp("last", e.last, a.last);
        end
      end
    end
  end

endmodule

FILE: test/lru_sector_cache_directory_top_tb.sv
// Testbench top that drives commands into the sector cache directory.
`timescale 1ns / 1ps
module lru_sector_cache_directory_top_tb;
  import lscd_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;
  int        fail_count, pending;
  int        cycle_count = 0;
  logic      hold_off = 1'b0;  // set while the receiver stalls on purpose

  // The limit covers flushes of 64 write-backs, long receiver stalls and the
  // full recency sweep on every miss, many times over.
  localparam int CycleLimit = 400000;

  always #1 clk_i = ~clk_i;

  lru_sector_cache_directory_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o
  );

  lscd_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_item_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_item_i(out_item_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // A small pool of tags keeps hits frequent; a pool wider than 64 entries
  // forces evictions of dirty victims.
  logic [DevW-1:0] pool_dev [96];
  logic [SecW-1:0] pool_sec [96];

  // Hand one item to the block and return once it has been accepted. The
  // sender sometimes drops valid for a random gap between bursts; within a
  // burst valid stays high and the next item follows at once.
  int burst_left = 0;
  task automatic send(op_e op, logic [DevW-1:0] d, logic [SecW-1:0] s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_item_i  <= '{cmd: op, dev_id: d, sector_num: s};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Mostly accesses on pooled tags, with occasional whole-range noise and
  // maintenance commands.
  task automatic send_random();
    int unsigned p, k;
    op_e op;
    p = $urandom_range(0, 95);
    k = $urandom_range(0, 99);
    if (k < 45)      op = CMD_READ;
    else if (k < 88) op = CMD_WRITE;
    else if (k < 93) op = CMD_FLUSH;
    else if (k < 95) op = CMD_INVAL;
    else if (k < 98) op = CMD_TAKE;
    else             op = op_e'($urandom_range(5, 7));
    if ($urandom_range(0, 9) == 0) send(op, DevW'($urandom), $urandom);
    else send(op, pool_dev[p], pool_sec[p]);
  endtask

  // Receiver stall pattern: random bursts, quiet stretches, and a long hold.
  always @(posedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else if (cycle_count % 1000 < 300) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int settle;
    for (int i = 0; i < 96; i++) begin
      pool_dev[i] = DevW'($urandom);
      pool_sec[i] = $urandom;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, every command, hit and miss for read and
    // write, flush with nothing dirty, unknown codes.
    send(CMD_FLUSH, 0, 0);
    send(CMD_READ, 4'h0, 32'h0);
    send(CMD_READ, 4'h0, 32'h0);
    send(CMD_WRITE, 4'hF, 32'hFFFF_FFFF);
    send(CMD_WRITE, 4'hF, 32'hFFFF_FFFF);
    send(CMD_READ, 4'hA, 32'h5555_AAAA);
    send(CMD_WRITE, 4'h5, 32'hAAAA_5555);
    send(CMD_FLUSH, 0, 0);
    send(CMD_FLUSH, 0, 0);
    send(CMD_TAKE, 4'hF, 32'hFFFF_FFFF);
    send(CMD_TAKE, 0, 0);
    send(op_e'(3'd5), 4'h3, 32'h1);
    send(op_e'(3'd6), 4'h3, 32'h1);
    send(CMD_OTHER, 4'hF, 32'hFFFF_FFFF);
    send(CMD_WRITE, 4'h1, 32'h1);
    send(CMD_READ, 4'h1, 32'h1);
    send(CMD_INVAL, 0, 0);
    send(CMD_INVAL, 0, 0);
    // Fill beyond capacity with dirty writes so that victims get written back.
    for (int i = 0; i < 70; i++) send(CMD_WRITE, pool_dev[i], pool_sec[i]);
    // Lots of dirty entries: flush while the receiver holds off, so the
    // block fills up and stalls its input.
    fork
      begin
        hold_off <= 1'b1;
        repeat (200) @(posedge clk_i);
        hold_off <= 1'b0;
      end
      begin
        send(CMD_FLUSH, 0, 0);
        for (int i = 0; i < 6; i++) send_random();
      end
    join

    for (int i = 0; i < 330; i++) send_random();
    send(CMD_INVAL, 0, 0);
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    settle = 0;
    while (settle < 200) begin
      @(posedge clk_i);
      settle++;
    end
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
